### src/lobm_pkg.sv
`default_nettype none

package lobm_pkg;

	localparam int ACTION_W = 3;
	localparam int USER_W   = 8;
	localparam int VOL_W    = 20;
	localparam int PRICE_W  = 20;
	localparam int STATUS_W = 4;
	localparam int ID_W     = 32;
	localparam int BAL_W    = 48;
	localparam int RUB_W    = VOL_W + PRICE_W;

	localparam logic [ACTION_W-1:0] ACT_BUY      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SELL     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_TRADE        = 4'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MATCH     = 4'd1;
	localparam logic [STATUS_W-1:0] ST_DONE         = 4'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_PARAMS   = 4'd3;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN_USER = 4'd4;
	localparam logic [STATUS_W-1:0] ST_BOOK_FULL    = 4'd5;
	localparam logic [STATUS_W-1:0] ST_BALANCE      = 4'd6;
	localparam logic [STATUS_W-1:0] ST_REGISTERED   = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLEARED      = 4'd8;

	// book memory is split in two halves by the top address bit
	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0]   volume;
		logic [ID_W-1:0]    id;
		logic [USER_W-1:0]  owner;
	} book_ent_t;

	typedef struct packed {
		logic signed [BAL_W-1:0] usd;
		logic signed [BAL_W-1:0] rub;
	} bal_t;

endpackage

`default_nettype wire

### src/lobm_req_if.sv
`default_nettype none

interface lobm_req_if;
	logic                             valid;
	logic                             ready;
	logic [lobm_pkg::ACTION_W-1:0]    action;
	logic [lobm_pkg::USER_W-1:0]      user_id;
	logic [lobm_pkg::VOL_W-1:0]       volume;
	logic [lobm_pkg::PRICE_W-1:0]     price;

	modport source(output valid, action, user_id, volume, price, input ready);
	modport sink(input valid, action, user_id, volume, price, output ready);
endinterface

`default_nettype wire

### src/lobm_res_if.sv
`default_nettype none

interface lobm_res_if;
	logic                              valid;
	logic                              ready;
	logic [lobm_pkg::STATUS_W-1:0]     status;
	logic [lobm_pkg::VOL_W-1:0]        trade_volume;
	logic [lobm_pkg::PRICE_W-1:0]      trade_price;
	logic [lobm_pkg::ID_W-1:0]         order_id;
	logic [lobm_pkg::USER_W-1:0]       reply_user;
	logic signed [lobm_pkg::BAL_W-1:0] usd_balance;
	logic signed [lobm_pkg::BAL_W-1:0] rub_balance;
	logic                              last;

	modport source(output valid, status, trade_volume, trade_price, order_id, reply_user,
		usd_balance, rub_balance, last, input ready);
	modport sink(input valid, status, trade_volume, trade_price, order_id, reply_user,
		usd_balance, rub_balance, last, output ready);
endinterface

`default_nettype wire

### src/lobm_ram.sv
`default_nettype none

module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/limit_order_book_matcher.sv
// Limit order book matcher, price-time priority.
// req channel (sink): one request per item: buy, sell, balance query, register
//   user, clear book. Taken only while the matcher is idle.
// res channel (source): one or more results per request, the final one with
//   last set; each trade of an order gives its own result ahead of the final.
// An order walks the opposite side, one result per trade; a buy that emptied
//   sell entries then compacts the sell side by moving the rest down, and a
//   remainder is inserted by shifting higher priced entries up one place.
//   Each step of the walk is a read, modify and write of the book memory and the
//   balance memory, each with one write port and a registered read port.
// The result register holds one result; while the receiver stalls, the matcher
//   waits at its next result and does not take a new request until the item is
//   finished. A request arriving while the last result still waits is taken.
// Reset clears the book counts, the user count and the order number. Book and
//   balance memories are not cleared; only written entries are ever read.
`default_nettype none

module limit_order_book_matcher #(
	parameter int BOOK_DEPTH = 32,
	parameter int MAX_USERS  = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	lobm_req_if.sink   req,
	lobm_res_if.source res
);

	localparam int AW  = $clog2(BOOK_DEPTH);
	localparam int CW  = $clog2(BOOK_DEPTH + 1);
	localparam int UW  = $clog2(MAX_USERS);
	localparam int UCW = $clog2(MAX_USERS + 1);
	localparam int BAL_W = lobm_pkg::BAL_W;

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_QUERY, S_WALK, S_CHECK, S_MUL, S_BAL1, S_BAL2_RD, S_BAL2,
		S_CMP_RD, S_CMP_WR, S_INS, S_INS_RD, S_INS_CHK, S_FINAL
	} state_t;

	state_t state_q, ret_q;

	logic [CW-1:0]  buy_cnt_q, sell_cnt_q, idx_q, dst_q, kill_q;
	logic [UCW-1:0] user_cnt_q;
	logic [lobm_pkg::ID_W-1:0] next_id_q, id_q;
	logic is_buy_q, traded_q, full_q;
	logic [lobm_pkg::USER_W-1:0]  user_q;
	logic [lobm_pkg::PRICE_W-1:0] pr_q;
	logic [lobm_pkg::VOL_W-1:0]   rem_q, tv_q;
	logic [lobm_pkg::RUB_W-1:0]   rub_q;
	lobm_pkg::book_ent_t ent_q;

	// pending result and output register
	logic [lobm_pkg::STATUS_W-1:0] p_status_q, o_status_q;
	logic [lobm_pkg::VOL_W-1:0]    p_vol_q, o_vol_q;
	logic [lobm_pkg::PRICE_W-1:0]  p_price_q, o_price_q;
	logic [lobm_pkg::ID_W-1:0]     p_id_q, o_id_q;
	logic [lobm_pkg::USER_W-1:0]   p_user_q, o_user_q;
	logic signed [BAL_W-1:0]       p_usd_q, o_usd_q, p_rub_q, o_rub_q;
	logic                          p_last_q, o_last_q, o_valid_q;

	// memories
	logic                  book_we;
	logic [AW:0]           book_waddr, book_raddr;
	lobm_pkg::book_ent_t   book_wdata, rd_ent;
	logic [$bits(lobm_pkg::book_ent_t)-1:0] book_rdata;
	logic                  bal_we;
	logic [UW-1:0]         bal_waddr, bal_raddr;
	lobm_pkg::bal_t        bal_wdata, bal_rd;
	logic [$bits(lobm_pkg::bal_t)-1:0] bal_rdata;

	logic acc, out_free, user_known, walk_more, price_ok, walk_side, ins_side;
	logic [CW-1:0] walk_rd_idx, idx_m1, ins_cnt;
	logic [lobm_pkg::VOL_W-1:0] tv;
	logic [lobm_pkg::RUB_W-1:0] prod;
	lobm_pkg::book_ent_t new_ent;

	function automatic logic signed [BAL_W-1:0] sat48(input logic signed [BAL_W:0] s);
		logic signed [BAL_W-1:0] r;
		if (s[BAL_W] != s[BAL_W-1]) begin
			r = s[BAL_W] ? {1'b1, {(BAL_W-1){1'b0}}} : {1'b0, {(BAL_W-1){1'b1}}};
		end else begin
			r = s[BAL_W-1:0];
		end
		return r;
	endfunction

	function automatic lobm_pkg::bal_t bal_move(input lobm_pkg::bal_t b, input logic gets_usd,
			input logic [lobm_pkg::VOL_W-1:0] v, input logic [lobm_pkg::RUB_W-1:0] r);
		logic signed [BAL_W:0] u_old, r_old, dv, dr;
		lobm_pkg::bal_t o;
		u_old = $signed({b.usd[BAL_W-1], b.usd});
		r_old = $signed({b.rub[BAL_W-1], b.rub});
		dv = $signed({{(BAL_W+1-lobm_pkg::VOL_W){1'b0}}, v});
		dr = $signed({{(BAL_W+1-lobm_pkg::RUB_W){1'b0}}, r});
		if (gets_usd) begin
			o.usd = sat48(u_old + dv);
			o.rub = sat48(r_old - dr);
		end else begin
			o.usd = sat48(u_old - dv);
			o.rub = sat48(r_old + dr);
		end
		return o;
	endfunction

	assign acc        = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign out_free   = !o_valid_q || res.ready;
	assign user_known = 32'(req.user_id) < 32'(user_cnt_q);

	assign rd_ent = lobm_pkg::book_ent_t'(book_rdata);
	assign bal_rd = lobm_pkg::bal_t'(bal_rdata);

	assign walk_side   = is_buy_q ? lobm_pkg::SIDE_SELL : lobm_pkg::SIDE_BUY;
	assign ins_side    = is_buy_q ? lobm_pkg::SIDE_BUY : lobm_pkg::SIDE_SELL;
	assign ins_cnt     = is_buy_q ? buy_cnt_q : sell_cnt_q;
	assign idx_m1      = idx_q - CW'(1);
	assign walk_rd_idx = is_buy_q ? idx_q : idx_m1;
	// buys walk the sell side upward, sells walk the buy side downward
	assign walk_more   = (rem_q != '0) && (is_buy_q ? (idx_q < sell_cnt_q) : (idx_q != '0));
	assign price_ok    = is_buy_q ? (rd_ent.price <= pr_q) : (rd_ent.price >= pr_q);
	assign tv          = (rem_q < rd_ent.volume) ? rem_q : rd_ent.volume;
	assign prod        = tv_q * ent_q.price;

	always_comb begin
		new_ent.price  = pr_q;
		new_ent.volume = rem_q;
		new_ent.id     = id_q;
		new_ent.owner  = user_q;
	end

	always_comb begin
		book_we    = 1'b0;
		book_waddr = '0;
		book_wdata = ent_q;
		book_raddr = '0;
		unique case (state_q)
			S_WALK:    book_raddr = {walk_side, walk_rd_idx[AW-1:0]};
			S_CMP_RD:  book_raddr = {lobm_pkg::SIDE_SELL, idx_q[AW-1:0]};
			S_CMP_WR: begin
				book_we    = 1'b1;
				book_waddr = {lobm_pkg::SIDE_SELL, dst_q[AW-1:0]};
				book_wdata = rd_ent;
			end
			S_BAL2: begin
				book_we    = (ent_q.volume != '0);
				book_waddr = {walk_side, idx_q[AW-1:0]};
			end
			S_INS_RD: begin
				book_raddr = {ins_side, idx_m1[AW-1:0]};
				book_we    = (idx_q == '0);
				book_waddr = {ins_side, idx_q[AW-1:0]};
				book_wdata = new_ent;
			end
			S_INS_CHK: begin
				// shift a higher priced entry up one place, or drop the new one in
				book_we    = 1'b1;
				book_waddr = {ins_side, idx_q[AW-1:0]};
				book_wdata = (rd_ent.price > pr_q) ? rd_ent : new_ent;
			end
			default: ;
		endcase
	end

	always_comb begin
		bal_we    = 1'b0;
		bal_waddr = user_cnt_q[UW-1:0];
		bal_wdata = '0;
		bal_raddr = UW'(req.user_id);
		unique case (state_q)
			S_IDLE: bal_we = acc && (req.action == lobm_pkg::ACT_REGISTER) &&
				(user_cnt_q < UCW'(MAX_USERS));
			S_MUL:  bal_raddr = UW'(user_q);
			S_BAL1: begin
				bal_we    = 1'b1;
				bal_waddr = UW'(user_q);
				bal_wdata = bal_move(bal_rd, is_buy_q, tv_q, rub_q);
			end
			// owner read waits for the incoming user's write to land
			S_BAL2_RD: bal_raddr = UW'(ent_q.owner);
			S_BAL2: begin
				bal_we    = 1'b1;
				bal_waddr = UW'(ent_q.owner);
				bal_wdata = bal_move(bal_rd, !is_buy_q, tv_q, rub_q);
			end
			default: ;
		endcase
	end

	lobm_ram #(
		.WIDTH($bits(lobm_pkg::book_ent_t)),
		.DEPTH(2 * (1 << AW))
	) u_book_ram (
		.clk  (clk),
		.we   (book_we),
		.waddr(book_waddr),
		.wdata(book_wdata),
		.raddr(book_raddr),
		.rdata(book_rdata)
	);

	lobm_ram #(
		.WIDTH($bits(lobm_pkg::bal_t)),
		.DEPTH(1 << UW)
	) u_bal_ram (
		.clk  (clk),
		.we   (bal_we),
		.waddr(bal_waddr),
		.wdata(bal_wdata),
		.raddr(bal_raddr),
		.rdata(bal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			buy_cnt_q  <= '0;
			sell_cnt_q <= '0;
			user_cnt_q <= '0;
			next_id_q  <= '0;
			idx_q      <= '0;
			dst_q      <= '0;
			kill_q     <= '0;
			id_q       <= '0;
			is_buy_q   <= 1'b0;
			traded_q   <= 1'b0;
			full_q     <= 1'b0;
			user_q     <= '0;
			pr_q       <= '0;
			rem_q      <= '0;
			tv_q       <= '0;
			rub_q      <= '0;
			ent_q      <= '0;
			p_status_q <= '0;
			p_vol_q    <= '0;
			p_price_q  <= '0;
			p_id_q     <= '0;
			p_user_q   <= '0;
			p_usd_q    <= '0;
			p_rub_q    <= '0;
			p_last_q   <= 1'b0;
			o_status_q <= '0;
			o_vol_q    <= '0;
			o_price_q  <= '0;
			o_id_q     <= '0;
			o_user_q   <= '0;
			o_usd_q    <= '0;
			o_rub_q    <= '0;
			o_last_q   <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			// S_EMIT reloads the output register itself
			if (res.ready && state_q != S_EMIT) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (acc) begin
					p_vol_q   <= '0;
					p_price_q <= '0;
					p_id_q    <= '0;
					p_user_q  <= '0;
					p_usd_q   <= '0;
					p_rub_q   <= '0;
					p_last_q  <= 1'b1;
					ret_q     <= S_IDLE;
					state_q   <= S_EMIT;
					is_buy_q  <= (req.action == lobm_pkg::ACT_BUY);
					user_q    <= req.user_id;
					pr_q      <= req.price;
					rem_q     <= req.volume;
					traded_q  <= 1'b0;
					full_q    <= 1'b0;
					kill_q    <= '0;
					case (req.action)
						lobm_pkg::ACT_QUERY: begin
							if (user_known) begin
								state_q <= S_QUERY;
							end else begin
								p_status_q <= lobm_pkg::ST_UNKNOWN_USER;
							end
						end
						lobm_pkg::ACT_REGISTER: begin
							if (user_cnt_q < UCW'(MAX_USERS)) begin
								p_status_q <= lobm_pkg::ST_REGISTERED;
								p_user_q   <= 8'(user_cnt_q);
								user_cnt_q <= user_cnt_q + UCW'(1);
							end else begin
								p_status_q <= lobm_pkg::ST_CLEARED;
							end
						end
						lobm_pkg::ACT_CLEAR: begin
							buy_cnt_q  <= '0;
							sell_cnt_q <= '0;
							p_status_q <= lobm_pkg::ST_CLEARED;
						end
						lobm_pkg::ACT_BUY, lobm_pkg::ACT_SELL: begin
							if (req.volume == '0 || req.price == '0) begin
								p_status_q <= lobm_pkg::ST_BAD_PARAMS;
							end else if (!user_known) begin
								p_status_q <= lobm_pkg::ST_UNKNOWN_USER;
							end else begin
								id_q      <= next_id_q;
								next_id_q <= next_id_q + 32'd1;
								idx_q     <= (req.action == lobm_pkg::ACT_BUY) ? '0 : buy_cnt_q;
								state_q   <= S_WALK;
							end
						end
						default: p_status_q <= lobm_pkg::ST_BAD_PARAMS;
					endcase
				end
				S_EMIT: if (out_free) begin
					o_status_q <= p_status_q;
					o_vol_q    <= p_vol_q;
					o_price_q  <= p_price_q;
					o_id_q     <= p_id_q;
					o_user_q   <= p_user_q;
					o_usd_q    <= p_usd_q;
					o_rub_q    <= p_rub_q;
					o_last_q   <= p_last_q;
					o_valid_q  <= 1'b1;
					state_q    <= ret_q;
				end
				S_QUERY: begin
					p_status_q <= lobm_pkg::ST_BALANCE;
					p_user_q   <= user_q;
					p_usd_q    <= bal_rd.usd;
					p_rub_q    <= bal_rd.rub;
					state_q    <= S_EMIT;
				end
				S_WALK: begin
					if (walk_more) begin
						state_q <= S_CHECK;
					end else if (is_buy_q && kill_q != '0) begin
						idx_q   <= kill_q;
						dst_q   <= '0;
						state_q <= S_CMP_RD;
					end else begin
						state_q <= S_INS;
					end
				end
				S_CHECK: begin
					if (price_ok) begin
						ent_q <= lobm_pkg::book_ent_t'({rd_ent.price, rd_ent.volume - tv,
							rd_ent.id, rd_ent.owner});
						tv_q  <= tv;
						if (!is_buy_q) begin
							idx_q <= idx_m1;
						end
						state_q <= S_MUL;
					end else if (is_buy_q && kill_q != '0) begin
						idx_q   <= kill_q;
						dst_q   <= '0;
						state_q <= S_CMP_RD;
					end else begin
						state_q <= S_INS;
					end
				end
				S_MUL: begin
					rub_q   <= prod;
					rem_q   <= rem_q - tv_q;
					state_q <= S_BAL1;
				end
				S_BAL1:    state_q <= S_BAL2_RD;
				S_BAL2_RD: state_q <= S_BAL2;
				S_BAL2: begin
					p_status_q <= lobm_pkg::ST_TRADE;
					p_vol_q    <= tv_q;
					p_price_q  <= ent_q.price;
					p_id_q     <= id_q;
					p_last_q   <= 1'b0;
					traded_q   <= 1'b1;
					ret_q      <= S_WALK;
					state_q    <= S_EMIT;
					if (is_buy_q) begin
						// emptied sells form a prefix, squeezed out after the walk
						idx_q <= idx_q + CW'(1);
						if (ent_q.volume == '0) begin
							kill_q <= kill_q + CW'(1);
						end
					end else if (ent_q.volume == '0) begin
						// emptied buys form a suffix
						buy_cnt_q <= idx_q;
					end
				end
				S_CMP_RD: begin
					if (idx_q < sell_cnt_q) begin
						state_q <= S_CMP_WR;
					end else begin
						sell_cnt_q <= sell_cnt_q - kill_q;
						state_q    <= S_INS;
					end
				end
				S_CMP_WR: begin
					idx_q   <= idx_q + CW'(1);
					dst_q   <= dst_q + CW'(1);
					state_q <= S_CMP_RD;
				end
				S_INS: begin
					if (rem_q == '0) begin
						state_q <= S_FINAL;
					end else if (ins_cnt >= CW'(BOOK_DEPTH)) begin
						full_q  <= 1'b1;
						state_q <= S_FINAL;
					end else begin
						idx_q   <= ins_cnt;
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (idx_q == '0) begin
						if (is_buy_q) begin
							buy_cnt_q <= buy_cnt_q + CW'(1);
						end else begin
							sell_cnt_q <= sell_cnt_q + CW'(1);
						end
						state_q <= S_FINAL;
					end else begin
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					if (rd_ent.price > pr_q) begin
						idx_q   <= idx_m1;
						state_q <= S_INS_RD;
					end else begin
						if (is_buy_q) begin
							buy_cnt_q <= buy_cnt_q + CW'(1);
						end else begin
							sell_cnt_q <= sell_cnt_q + CW'(1);
						end
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					p_status_q <= full_q ? lobm_pkg::ST_BOOK_FULL :
						(traded_q ? lobm_pkg::ST_DONE : lobm_pkg::ST_NO_MATCH);
					p_vol_q    <= '0;
					p_price_q  <= '0;
					p_id_q     <= id_q;
					p_last_q   <= 1'b1;
					ret_q      <= S_IDLE;
					state_q    <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid        = o_valid_q;
	assign res.status       = o_status_q;
	assign res.trade_volume = o_vol_q;
	assign res.trade_price  = o_price_q;
	assign res.order_id     = o_id_q;
	assign res.reply_user   = o_user_q;
	assign res.usd_balance  = o_usd_q;
	assign res.rub_balance  = o_rub_q;
	assign res.last         = o_last_q;

`ifndef SYNTHESIS
	a_book_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(buy_cnt_q <= CW'(BOOK_DEPTH)) && (sell_cnt_q <= CW'(BOOK_DEPTH)))
		else $error("book count beyond depth");

	a_user_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		user_cnt_q <= UCW'(MAX_USERS))
		else $error("user count beyond table size");

	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == lobm_pkg::ST_TRADE) |-> !res.last)
		else $error("trade result marked last");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");
`endif

endmodule

`default_nettype wire

### tb/limit_order_book_matcher_test.sv
`default_nettype none

module limit_order_book_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACTION_W = lobm_pkg::ACTION_W;
	localparam int USER_W   = lobm_pkg::USER_W;
	localparam int VOL_W    = lobm_pkg::VOL_W;
	localparam int PRICE_W  = lobm_pkg::PRICE_W;
	localparam int STATUS_W = lobm_pkg::STATUS_W;
	localparam int ID_W     = lobm_pkg::ID_W;
	localparam int BAL_W    = lobm_pkg::BAL_W;

	localparam int DEPTH = 32;
	localparam int USERS = 256;
	localparam int STALL_LIMIT = 20000;
	localparam longint BMAX = 64'sh00007FFFFFFFFFFF;
	localparam longint BMIN = -BMAX - 1;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [VOL_W-1:0]    tvol;
		logic [PRICE_W-1:0]  tprice;
		logic [ID_W-1:0]     oid;
		logic [USER_W-1:0]   ruser;
		logic signed [BAL_W-1:0] usd;
		logic signed [BAL_W-1:0] rub;
		logic                last;
	} fill_t;

	typedef struct {
		logic [PRICE_W-1:0] price;
		logic [VOL_W-1:0]   vol;
		logic [ID_W-1:0]    id;
		logic [USER_W-1:0]  owner;
	} rest_t;

	class book_scoreboard;
		rest_t bids[$];
		rest_t asks[$];
		longint usd_bal[USERS];
		longint rub_bal[USERS];
		int unsigned n_users;
		logic [ID_W-1:0] next_id;
		fill_t pending[$];
		int errors;

		function new();
			n_users = 0;
			next_id = '0;
			errors = 0;
		endfunction

		function longint sat(longint v);
			if (v > BMAX) return BMAX;
			if (v < BMIN) return BMIN;
			return v;
		endfunction

		function void move(int u, bit gets_usd, longint v, longint r);
			if (gets_usd) begin
				usd_bal[u] = sat(usd_bal[u] + v);
				rub_bal[u] = sat(rub_bal[u] - r);
			end else begin
				usd_bal[u] = sat(usd_bal[u] - v);
				rub_bal[u] = sat(rub_bal[u] + r);
			end
		endfunction

		function void push(logic [STATUS_W-1:0] st, logic [VOL_W-1:0] v,
			logic [PRICE_W-1:0] p, logic [ID_W-1:0] id, logic [USER_W-1:0] u,
			longint usd, longint rub, logic lst);
			fill_t f;
			f.status = st; f.tvol = v; f.tprice = p; f.oid = id; f.ruser = u;
			f.usd = usd[BAL_W-1:0]; f.rub = rub[BAL_W-1:0]; f.last = lst;
			pending.push_back(f);
		endfunction

		// insert after all entries of equal or lower price
		function bit rest(ref rest_t side[$], rest_t e);
			int pos;
			if (side.size() >= DEPTH) return 0;
			pos = 0;
			while (pos < side.size() && side[pos].price <= e.price) pos++;
			side.insert(pos, e);
			return 1;
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, logic [USER_W-1:0] u,
			logic [VOL_W-1:0] vol, logic [PRICE_W-1:0] pr);
			logic [ID_W-1:0] id;
			longint remv, tv, rub;
			int i, n;
			bit ok;
			rest_t e;
			if (act == lobm_pkg::ACT_QUERY) begin
				if (u >= n_users) push(lobm_pkg::ST_UNKNOWN_USER, 0, 0, 0, 0, 0, 0, 1);
				else push(lobm_pkg::ST_BALANCE, 0, 0, 0, u, usd_bal[u], rub_bal[u], 1);
				return;
			end
			if (act == lobm_pkg::ACT_REGISTER) begin
				if (n_users >= USERS) begin
					push(lobm_pkg::ST_CLEARED, 0, 0, 0, 0, 0, 0, 1);
					return;
				end
				usd_bal[n_users] = 0;
				rub_bal[n_users] = 0;
				push(lobm_pkg::ST_REGISTERED, 0, 0, 0, n_users[USER_W-1:0], 0, 0, 1);
				n_users++;
				return;
			end
			if (act == lobm_pkg::ACT_CLEAR) begin
				bids.delete();
				asks.delete();
				push(lobm_pkg::ST_CLEARED, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			if (act > lobm_pkg::ACT_CLEAR || vol == 0 || pr == 0) begin
				push(lobm_pkg::ST_BAD_PARAMS, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			if (u >= n_users) begin
				push(lobm_pkg::ST_UNKNOWN_USER, 0, 0, 0, 0, 0, 0, 1);
				return;
			end
			id = next_id;
			next_id++;
			remv = vol;
			n = 0;
			if (act == lobm_pkg::ACT_BUY) begin
				i = 0;
				while (remv > 0 && i < asks.size() && asks[i].price <= pr) begin
					tv = (remv < asks[i].vol) ? remv : asks[i].vol;
					rub = tv * asks[i].price;
					move(u, 1, tv, rub);
					move(asks[i].owner, 0, tv, rub);
					remv -= tv;
					asks[i].vol -= tv[VOL_W-1:0];
					push(lobm_pkg::ST_TRADE, tv[VOL_W-1:0], asks[i].price, id, 0, 0, 0, 0);
					n++;
					if (asks[i].vol == 0) asks.delete(i);
					else i++;
				end
			end else begin
				i = bids.size();
				while (remv > 0 && i > 0 && bids[i-1].price >= pr) begin
					i--;
					tv = (remv < bids[i].vol) ? remv : bids[i].vol;
					rub = tv * bids[i].price;
					move(u, 0, tv, rub);
					move(bids[i].owner, 1, tv, rub);
					remv -= tv;
					bids[i].vol -= tv[VOL_W-1:0];
					push(lobm_pkg::ST_TRADE, tv[VOL_W-1:0], bids[i].price, id, 0, 0, 0, 0);
					n++;
					if (bids[i].vol == 0) bids.delete(i);
				end
			end
			ok = 1;
			if (remv > 0) begin
				e.price = pr; e.vol = remv[VOL_W-1:0]; e.id = id; e.owner = u;
				ok = (act == lobm_pkg::ACT_BUY) ? rest(bids, e) : rest(asks, e);
			end
			push(!ok ? lobm_pkg::ST_BOOK_FULL :
				(n > 0 ? lobm_pkg::ST_DONE : lobm_pkg::ST_NO_MATCH), 0, 0, id, 0, 0, 0, 1);
		endfunction

		function void check_result(fill_t got);
			fill_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, got.status);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.tvol !== want.tvol
				|| got.tprice !== want.tprice || got.oid !== want.oid
				|| got.ruser !== want.ruser || got.usd !== want.usd
				|| got.rub !== want.rub || got.last !== want.last) begin
				$display("%0t: expected st=%0d vol=%0d pr=%0d id=%0d usr=%0d usd=%0d rub=%0d last=%0d",
					$time, want.status, want.tvol, want.tprice, want.oid, want.ruser,
					want.usd, want.rub, want.last);
				$display("%0t: actual   st=%0d vol=%0d pr=%0d id=%0d usr=%0d usd=%0d rub=%0d last=%0d",
					$time, got.status, got.tvol, got.tprice, got.oid, got.ruser,
					got.usd, got.rub, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	lobm_req_if req();
	lobm_res_if res();

	limit_order_book_matcher dut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));

	always #4 clk = ~clk;

	book_scoreboard sb = new();
	bit calm = 0;
	bit hold_off = 0;
	bit stim_done = 0;
	int idle_cycles = 0;

	initial begin
		req.valid = 0; req.action = '0; req.user_id = '0; req.volume = '0; req.price = '0;
		res.ready = 0;
	end

	always @(posedge clk) begin
		fill_t f;
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.action, req.user_id, req.volume, req.price);
			if (res.valid && res.ready) begin
				f.status = res.status; f.tvol = res.trade_volume; f.tprice = res.trade_price;
				f.oid = res.order_id; f.ruser = res.reply_user; f.usd = res.usd_balance;
				f.rub = res.rub_balance; f.last = res.last;
				sb.check_result(f);
			end
			if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off
	always @(negedge clk) begin
		if (hold_off) res.ready <= 0;
		else if (calm) res.ready <= 1;
		else res.ready <= ($urandom_range(99) >= 32);
	end

	task automatic send(logic [ACTION_W-1:0] act, logic [USER_W-1:0] u,
		logic [VOL_W-1:0] vol, logic [PRICE_W-1:0] pr);
		while (!calm && $urandom_range(99) < 32) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1; req.action <= act; req.user_id <= u;
		req.volume <= vol; req.price <= pr;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic rand_order(int users);
		logic [ACTION_W-1:0] act;
		logic [VOL_W-1:0] v;
		logic [PRICE_W-1:0] p;
		int r;
		act = $urandom_range(1) ? lobm_pkg::ACT_SELL : lobm_pkg::ACT_BUY;
		r = $urandom_range(99);
		v = (r < 5) ? VOL_W'($urandom()) : VOL_W'($urandom_range(1, 50));
		p = (r < 5) ? PRICE_W'($urandom()) : PRICE_W'($urandom_range(95, 105));
		if ($urandom_range(99) < 3) v = 0;
		if ($urandom_range(99) < 3) p = 0;
		send(act, USER_W'($urandom_range(users - 1)), v, p);
	endtask

	initial begin
		int k;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed
		send(lobm_pkg::ACT_QUERY, 0, 1, 1);
		send(lobm_pkg::ACT_BUY, 0, 10, 10);
		send(lobm_pkg::ACT_REGISTER, 8'hFF, 0, 0);
		send(lobm_pkg::ACT_REGISTER, 0, 0, 0);
		send(lobm_pkg::ACT_REGISTER, 0, 0, 0);
		send(lobm_pkg::ACT_BUY, 0, 0, 5);
		send(lobm_pkg::ACT_SELL, 0, 5, 0);
		send(3'd5, 0, 5, 5);
		send(3'd7, 8'hFF, 20'hFFFFF, 20'hFFFFF);
		send(lobm_pkg::ACT_BUY, 5, 5, 5);
		send(lobm_pkg::ACT_SELL, 1, 20'hFFFFF, 20'hFFFFF);
		send(lobm_pkg::ACT_BUY, 0, 20'hFFFFF, 20'hFFFFF);
		send(lobm_pkg::ACT_SELL, 0, 3, 100);
		send(lobm_pkg::ACT_SELL, 1, 3, 100);
		send(lobm_pkg::ACT_SELL, 2, 4, 90);
		send(lobm_pkg::ACT_BUY, 2, 20, 100);
		send(lobm_pkg::ACT_BUY, 1, 5, 50);
		send(lobm_pkg::ACT_BUY, 0, 5, 50);
		send(lobm_pkg::ACT_SELL, 2, 7, 1);
		send(lobm_pkg::ACT_QUERY, 0, 0, 0);
		send(lobm_pkg::ACT_QUERY, 1, 0, 0);
		send(lobm_pkg::ACT_QUERY, 2, 0, 0);
		send(lobm_pkg::ACT_CLEAR, 0, 0, 0);
		// fill one side past the depth
		for (k = 0; k < DEPTH + 2; k++)
			send(lobm_pkg::ACT_BUY, USER_W'(k % 3), 1, PRICE_W'(k + 1));
		send(lobm_pkg::ACT_SELL, 1, 20'hFFFFF, 1);
		send(lobm_pkg::ACT_CLEAR, 0, 0, 0);
		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			for (k = 0; k < 10; k++) rand_order(2);
		join
		calm = 1;
		for (k = 0; k < 40; k++) rand_order(3);
		calm = 0;
		for (k = 0; k < 110; k++) begin
			if ($urandom_range(99) < 78) rand_order(sb.n_users + 1 > 255 ? 255 : sb.n_users + 1);
			else case ($urandom_range(4))
				0: send(lobm_pkg::ACT_REGISTER, USER_W'($urandom()), VOL_W'($urandom()),
					PRICE_W'($urandom()));
				1: send(lobm_pkg::ACT_QUERY, USER_W'($urandom_range(sb.n_users)),
					VOL_W'($urandom()), PRICE_W'($urandom()));
				2: if ($urandom_range(9) == 0) send(lobm_pkg::ACT_CLEAR, USER_W'($urandom()), 0, 0);
					else send(lobm_pkg::ACT_QUERY, USER_W'($urandom()), 0, 0);
				3: send(ACTION_W'($urandom_range(5, 7)), USER_W'($urandom()),
					VOL_W'($urandom()), PRICE_W'($urandom()));
				default: send(lobm_pkg::ACT_REGISTER, 0, 0, 0);
			endcase
		end
		// exhaust the user table
		while (sb.n_users < USERS) send(lobm_pkg::ACT_REGISTER, 0, 0, 0);
		send(lobm_pkg::ACT_REGISTER, 0, 0, 0);
		send(lobm_pkg::ACT_QUERY, 8'hFF, 0, 0);
		req.valid <= 0;
		stim_done = 1;
	end

	initial begin
		int w;
		wait (stim_done);
		w = 0;
		while (sb.pending.size() != 0 && w < 100000) begin
			@(posedge clk);
			w++;
		end
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

`default_nettype wire
